// ===== sv/utte_pkg.sv =====
// shared types, codes and reset constants of the user and token table engine
`default_nettype none

package utte_pkg;

    // default table sizes
    localparam int DEF_USER_SLOTS  = 16;
    localparam int DEF_TOKEN_SLOTS = 64;

    // field widths
    localparam int ACT_W  = 3;
    localparam int ST_W   = 3;
    localparam int DATA_W = 32;

    // action codes
    localparam logic [ACT_W-1:0] ACT_LOGIN   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_VERIFY  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REVOKE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ADDUSER = 3'd3;
    localparam logic [ACT_W-1:0] ACT_STATUS  = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK          = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND   = 3'd1;
    localparam logic [ST_W-1:0] ST_TOKENS_FULL = 3'd2;
    localparam logic [ST_W-1:0] ST_USER_EXISTS = 3'd3;
    localparam logic [ST_W-1:0] ST_USERS_FULL  = 3'd4;

    // built-in users and first token id
    localparam logic [DATA_W-1:0] ROOT_UID   = 32'd0;
    localparam logic [DATA_W-1:0] ROOT_MASK  = 32'h0000_00FF;
    localparam logic [DATA_W-1:0] ADMIN_UID  = 32'd1;
    localparam logic [DATA_W-1:0] ADMIN_MASK = 32'h0000_003F;
    localparam logic [DATA_W-1:0] ID_START   = 32'd1;

    // one user table entry
    typedef struct packed {
        logic              live;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] id;
    } t_user_ent;

    // one token table entry
    typedef struct packed {
        logic              live;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] owner;
        logic [DATA_W-1:0] id;
    } t_tok_ent;

endpackage

`default_nettype wire

// ===== sv/user_token_table_engine.sv =====
// user and token table engine: request sequencer over two dual-port table memories
// status and unknown actions answer without a scan; verify and revoke scan the token table;
//   add user scans the user table; login scans the user table, then the token table
// throughput: one request at a time, set by the linear scan through each table memory,
//   one entry read per cycle; a finished response may wait while the next request enters
// reset: synchronous, active low; afterwards a clearing pass over max(USER_SLOTS, TOKEN_SLOTS)
//   entries writes both tables (root and admin users, no tokens) before s_axis_tready rises
`default_nettype none

module user_token_table_engine #(
    parameter int USER_SLOTS  = utte_pkg::DEF_USER_SLOTS,
    parameter int TOKEN_SLOTS = utte_pkg::DEF_TOKEN_SLOTS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // action [2:0], lookup_key [34:3], new_cap_mask [66:35], zero fill [71:67]
    input  wire  [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // status [2:0], first_value [34:3], second_value [66:35], zero fill [71:67]
    output logic [71:0] m_axis_tdata
);

    localparam int UW      = $clog2(USER_SLOTS);
    localparam int TW      = (TOKEN_SLOTS > 1) ? $clog2(TOKEN_SLOTS) : 1;
    localparam int UCW     = $clog2(USER_SLOTS + 1);
    localparam int TCW     = $clog2(TOKEN_SLOTS + 1);
    localparam int CLR_LEN = (USER_SLOTS > TOKEN_SLOTS) ? USER_SLOTS : TOKEN_SLOTS;
    localparam int CW      = $clog2(CLR_LEN);
    localparam int DW      = utte_pkg::DATA_W;
    localparam int AW      = utte_pkg::ACT_W;
    localparam int SW      = utte_pkg::ST_W;

    localparam logic [UW-1:0] ULAST    = UW'(USER_SLOTS - 1);
    localparam logic [TW-1:0] TLAST    = TW'(TOKEN_SLOTS - 1);
    localparam logic [CW-1:0] CLR_LAST = CW'(CLR_LEN - 1);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_USCAN = 3'd2;
    localparam logic [2:0] S_TSCAN = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    // table memories and their registered read data
    utte_pkg::t_user_ent user_mem [USER_SLOTS];
    utte_pkg::t_tok_ent  tok_mem  [TOKEN_SLOTS];
    utte_pkg::t_user_ent r_urd;
    utte_pkg::t_tok_ent  r_trd;

    logic [2:0]     r_state, n_state;
    logic [AW-1:0]  r_act, n_act;
    logic [DW-1:0]  r_key, n_key;
    logic [DW-1:0]  r_newmask, n_newmask;
    logic [UW:0]    r_uptr, n_uptr;
    logic           r_udv, n_udv;
    logic [UW-1:0]  r_uidx, n_uidx;
    logic [TW:0]    r_tptr, n_tptr;
    logic           r_tdv, n_tdv;
    logic [TW-1:0]  r_tidx, n_tidx;
    logic           r_free_ok, n_free_ok;
    logic [UW-1:0]  r_free_idx, n_free_idx;
    logic [DW-1:0]  r_umask, n_umask;
    logic [DW-1:0]  r_ctr, n_ctr;
    logic [TCW-1:0] r_tcnt, n_tcnt;
    logic [UCW-1:0] r_ucnt, n_ucnt;
    logic [CW-1:0]  r_cptr, n_cptr;
    logic [SW-1:0]  r_res_st, n_res_st;
    logic [DW-1:0]  r_res_v1, n_res_v1;
    logic [DW-1:0]  r_res_v2, n_res_v2;
    logic           r_ovalid, n_ovalid;
    logic [SW-1:0]  r_ost, n_ost;
    logic [DW-1:0]  r_ov1, n_ov1;
    logic [DW-1:0]  r_ov2, n_ov2;

    logic                u_we;
    logic [UW-1:0]       u_waddr;
    utte_pkg::t_user_ent u_wdata;
    logic [UW-1:0]       u_raddr;
    logic                t_we;
    logic [TW-1:0]       t_waddr;
    utte_pkg::t_tok_ent  t_wdata;
    logic [TW-1:0]       t_raddr;

    logic u_hit, u_free, u_end;
    logic t_hit, t_end;

    // request fields
    logic [AW-1:0] in_act;
    logic [DW-1:0] in_key;
    logic [DW-1:0] in_mask;

    assign in_act  = s_axis_tdata[2:0];
    assign in_key  = s_axis_tdata[34:3];
    assign in_mask = s_axis_tdata[66:35];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_ov2, r_ov1, r_ost};

    // read addresses follow the scan pointers
    assign u_raddr = (r_uptr < (UW+1)'(USER_SLOTS)) ? r_uptr[UW-1:0] : '0;
    assign t_raddr = (r_tptr < (TW+1)'(TOKEN_SLOTS)) ? r_tptr[TW-1:0] : '0;

    // compare on the entry read in the previous cycle
    assign u_hit  = r_udv && r_urd.live && (r_urd.id == r_key);
    assign u_free = r_udv && !r_urd.live;
    assign u_end  = r_udv && (r_uidx == ULAST);
    assign t_hit  = r_tdv && ((r_act == utte_pkg::ACT_LOGIN) ? !r_trd.live
                                : (r_trd.live && (r_trd.id == r_key)));
    assign t_end  = r_tdv && (r_tidx == TLAST);

    // user table memory
    always_ff @(posedge i_clk) begin
        if (u_we) begin
            user_mem[u_waddr] <= u_wdata;
        end
        r_urd <= user_mem[u_raddr];
    end

    // token table memory
    always_ff @(posedge i_clk) begin
        if (t_we) begin
            tok_mem[t_waddr] <= t_wdata;
        end
        r_trd <= tok_mem[t_raddr];
    end

    // sequencer next state and table writes
    always_comb begin
        n_state    = r_state;
        n_act      = r_act;
        n_key      = r_key;
        n_newmask  = r_newmask;
        n_uptr     = r_uptr;
        n_udv      = r_udv;
        n_uidx     = r_uidx;
        n_tptr     = r_tptr;
        n_tdv      = r_tdv;
        n_tidx     = r_tidx;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        n_umask    = r_umask;
        n_ctr      = r_ctr;
        n_tcnt     = r_tcnt;
        n_ucnt     = r_ucnt;
        n_cptr     = r_cptr;
        n_res_st   = r_res_st;
        n_res_v1   = r_res_v1;
        n_res_v2   = r_res_v2;
        n_ovalid   = r_ovalid;
        n_ost      = r_ost;
        n_ov1      = r_ov1;
        n_ov2      = r_ov2;
        u_we       = 1'b0;
        u_waddr    = r_uidx;
        u_wdata    = '0;
        t_we       = 1'b0;
        t_waddr    = r_tidx;
        t_wdata    = r_trd;

        // response taken downstream
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            // write the reset contents of both tables
            S_CLEAR: begin
                u_we    = ({1'b0, r_cptr} < (CW+1)'(USER_SLOTS));
                u_waddr = r_cptr[UW-1:0];
                if (r_cptr == CW'(0)) begin
                    u_wdata = '{live: 1'b1, mask: utte_pkg::ROOT_MASK,
                                id: utte_pkg::ROOT_UID};
                end else if (r_cptr == CW'(1)) begin
                    u_wdata = '{live: 1'b1, mask: utte_pkg::ADMIN_MASK,
                                id: utte_pkg::ADMIN_UID};
                end
                t_we    = ({1'b0, r_cptr} < (CW+1)'(TOKEN_SLOTS));
                t_waddr = r_cptr[TW-1:0];
                t_wdata = '0;
                n_cptr  = r_cptr + 1'b1;
                if (r_cptr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end

            // take a request and pick the first scan, or go straight to the response
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_act     = in_act;
                    n_key     = in_key;
                    n_newmask = in_mask;
                    n_uptr    = '0;
                    n_udv     = 1'b0;
                    n_tptr    = '0;
                    n_tdv     = 1'b0;
                    n_free_ok = 1'b0;
                    n_res_v1  = '0;
                    n_res_v2  = '0;
                    case (in_act)
                        utte_pkg::ACT_LOGIN, utte_pkg::ACT_ADDUSER: begin
                            n_state = S_USCAN;
                        end
                        utte_pkg::ACT_VERIFY, utte_pkg::ACT_REVOKE: begin
                            n_state = S_TSCAN;
                        end
                        utte_pkg::ACT_STATUS: begin
                            n_res_st = utte_pkg::ST_OK;
                            n_res_v1 = DW'(r_tcnt);
                            n_res_v2 = DW'(r_ucnt);
                            n_state  = S_RESP;
                        end
                        default: begin
                            n_res_st = utte_pkg::ST_NOT_FOUND;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end

            // walk the user table
            S_USCAN: begin
                if (r_uptr < (UW+1)'(USER_SLOTS)) begin
                    n_uptr = r_uptr + 1'b1;
                    n_udv  = 1'b1;
                    n_uidx = r_uptr[UW-1:0];
                end else begin
                    n_udv = 1'b0;
                end
                if (u_free && !r_free_ok) begin
                    n_free_ok  = 1'b1;
                    n_free_idx = r_uidx;
                end
                if (u_hit) begin
                    if (r_act == utte_pkg::ACT_LOGIN) begin
                        n_umask = r_urd.mask;
                        n_state = S_TSCAN;
                    end else begin
                        n_res_st = utte_pkg::ST_USER_EXISTS;
                        n_state  = S_RESP;
                    end
                end else if (u_end) begin
                    n_state = S_RESP;
                    if (r_act == utte_pkg::ACT_LOGIN) begin
                        n_res_st = utte_pkg::ST_NOT_FOUND;
                    end else if (r_free_ok || u_free) begin
                        u_we     = 1'b1;
                        u_waddr  = r_free_ok ? r_free_idx : r_uidx;
                        u_wdata  = '{live: 1'b1, mask: r_newmask, id: r_key};
                        n_ucnt   = r_ucnt + 1'b1;
                        n_res_st = utte_pkg::ST_OK;
                    end else begin
                        n_res_st = utte_pkg::ST_USERS_FULL;
                    end
                end
            end

            // walk the token table
            S_TSCAN: begin
                if (r_tptr < (TW+1)'(TOKEN_SLOTS)) begin
                    n_tptr = r_tptr + 1'b1;
                    n_tdv  = 1'b1;
                    n_tidx = r_tptr[TW-1:0];
                end else begin
                    n_tdv = 1'b0;
                end
                if (t_hit) begin
                    n_state  = S_RESP;
                    n_res_st = utte_pkg::ST_OK;
                    case (r_act)
                        utte_pkg::ACT_LOGIN: begin
                            t_we     = 1'b1;
                            t_wdata  = '{live: 1'b1, mask: r_umask, owner: r_key, id: r_ctr};
                            n_res_v1 = r_ctr;
                            n_ctr    = r_ctr + 1'b1;
                            n_tcnt   = r_tcnt + 1'b1;
                        end
                        utte_pkg::ACT_VERIFY: begin
                            n_res_v1 = r_trd.owner;
                            n_res_v2 = r_trd.mask;
                        end
                        default: begin
                            t_we         = 1'b1;
                            t_wdata.live = 1'b0;
                            n_tcnt       = r_tcnt - 1'b1;
                        end
                    endcase
                end else if (t_end) begin
                    n_state = S_RESP;
                    case (r_act)
                        utte_pkg::ACT_LOGIN:  n_res_st = utte_pkg::ST_TOKENS_FULL;
                        utte_pkg::ACT_VERIFY: n_res_st = utte_pkg::ST_NOT_FOUND;
                        default:              n_res_st = utte_pkg::ST_OK;
                    endcase
                end
            end

            // move the result into the output register once it is free
            S_RESP: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_res_st;
                    n_ov1    = r_res_v1;
                    n_ov2    = r_res_v2;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cptr   <= '0;
            r_udv    <= 1'b0;
            r_tdv    <= 1'b0;
            r_ctr    <= utte_pkg::ID_START;
            r_tcnt   <= '0;
            r_ucnt   <= UCW'(2);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cptr   <= n_cptr;
            r_udv    <= n_udv;
            r_tdv    <= n_tdv;
            r_ctr    <= n_ctr;
            r_tcnt   <= n_tcnt;
            r_ucnt   <= n_ucnt;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_key      <= n_key;
        r_newmask  <= n_newmask;
        r_uptr     <= n_uptr;
        r_uidx     <= n_uidx;
        r_tptr     <= n_tptr;
        r_tidx     <= n_tidx;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_umask    <= n_umask;
        r_res_st   <= n_res_st;
        r_res_v1   <= n_res_v1;
        r_res_v2   <= n_res_v2;
        r_ost      <= n_ost;
        r_ov1      <= n_ov1;
        r_ov2      <= n_ov2;
    end

    // live token count never exceeds the table
    a_tcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tcnt <= TCW'(TOKEN_SLOTS))
        else $error("live token count beyond table size");

    // an accepted request always starts work
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // read data index trails the user scan pointer by one
    a_uscan_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_USCAN && r_udv) |-> (r_uptr == (UW+1)'(r_uidx) + 1'b1))
        else $error("user scan pointer and read index out of step");

    // both tables are written together only during the clearing pass
    a_dual_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (u_we && t_we) |-> (r_state == S_CLEAR))
        else $error("both tables written outside the clearing pass");

endmodule

`default_nettype wire
